>>> sv/gse_pkg.sv
// Shared types, constants and codes for the gait stance estimator.
// Used by every other file of the block; depends on nothing.
package gse_pkg;

    localparam int WINDOW_MAX = 16;
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int VAL_W      = 36;
    localparam int MED_W      = VAL_W + 1;
    localparam int TIME_W     = 48;
    localparam int FRAC_W     = 17;
    localparam int MS_W       = 16;
    localparam int NS_PER_MS  = 1000000;

    localparam logic [1:0] NOTE_NONE   = 2'd0;
    localparam logic [1:0] NOTE_GAP    = 2'd1;
    localparam logic [1:0] NOTE_CYCLE  = 2'd2;
    localparam logic [1:0] NOTE_STANCE = 2'd3;

    localparam logic [2:0] CFG_WINDOW_LEN = 3'd0;
    localparam logic [2:0] CFG_WARMUP     = 3'd1;
    localparam logic [2:0] CFG_GAP        = 3'd2;
    localparam logic [2:0] CFG_CYCLE_MIN  = 3'd3;
    localparam logic [2:0] CFG_CYCLE_MAX  = 3'd4;
    localparam logic [2:0] CFG_STANCE_MIN = 3'd5;
    localparam logic [2:0] CFG_STANCE_MAX = 3'd6;
    localparam logic [2:0] CFG_CADENCE    = 3'd7;

    typedef enum logic [1:0] {CELL_HOLD, CELL_LOAD, CELL_SHIFT} cell_op_t;

    typedef enum logic [2:0] {ROW_IDLE, ROW_PUSH, ROW_TRIM, ROW_POP, ROW_CLEAR} row_op_t;

    typedef struct packed {
        row_op_t          op;
        logic             med_clr;
        logic             med_step;
        logic [IDX_W-1:0] sel;
    } row_ctl_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [VAL_W-1:0] newest;
        logic [MED_W-1:0] med2;
    } row_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_THR, ST_EVAL, ST_DIV, ST_FPUSH, ST_TRIM,
        ST_MED, ST_CAD, ST_CHOOSE, ST_MUL0, ST_MUL1, ST_MUL2, ST_OUT
    } state_t;

endpackage

>>> sv/gse_cell.sv
// One window cell: holds a sample, shifts toward the oldest end, ranks itself.
// Depends on gse_pkg.
module gse_cell (
    input  logic                     clk,
    input  gse_pkg::cell_op_t        op,
    input  logic [gse_pkg::VAL_W-1:0] din,
    input  logic [gse_pkg::VAL_W-1:0] nb,
    input  logic [gse_pkg::VAL_W-1:0] cand,
    input  logic                     valid,
    output logic [gse_pkg::VAL_W-1:0] val,
    output logic                     lt,
    output logic                     le
);
    import gse_pkg::*;

    logic [VAL_W-1:0] val_reg;

    always_ff @(posedge clk)
    begin
        unique case (op)
            CELL_LOAD:  val_reg <= din;
            CELL_SHIFT: val_reg <= nb;
            default:    val_reg <= val_reg;
        endcase
    end

    assign val = val_reg;
    assign lt  = valid && (val_reg < cand);
    assign le  = valid && (val_reg <= cand);

endmodule

>>> sv/gse_row.sv
// A window of samples as a row of cells, with its fill count and median sweep.
// Depends on gse_pkg and gse_cell.
module gse_row (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gse_pkg::row_ctl_t         ctl,
    input  logic [gse_pkg::VAL_W-1:0] din,
    output gse_pkg::row_stat_t        stat
);
    import gse_pkg::*;

    logic [CNT_W-1:0]      count_reg;
    logic [VAL_W-1:0]      lo_reg;
    logic [VAL_W-1:0]      hi_reg;
    logic [VAL_W-1:0]      vals [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] lts;
    logic [WINDOW_MAX-1:0] les;
    cell_op_t              ops [WINDOW_MAX];
    logic [VAL_W-1:0]      cand;
    logic [CNT_W-1:0]      lt_cnt;
    logic [CNT_W-1:0]      le_cnt;
    logic [CNT_W-1:0]      k1;
    logic [CNT_W-1:0]      k2;
    logic [CNT_W-1:0]      count_m1;
    logic                  full;

    assign full     = (count_reg == CNT_W'(WINDOW_MAX));
    assign cand     = vals[ctl.sel];
    assign count_m1 = count_reg - 1'b1;

    always_comb
    begin
        for (int j = 0; j < WINDOW_MAX; j++)
        begin
            ops[j] = CELL_HOLD;
            if (ctl.op == ROW_PUSH)
            begin
                if (full)
                    ops[j] = (j == WINDOW_MAX - 1) ? CELL_LOAD : CELL_SHIFT;
                else if (count_reg == CNT_W'(j))
                    ops[j] = CELL_LOAD;
            end
            else if (ctl.op == ROW_TRIM)
            begin
                ops[j] = CELL_SHIFT;
            end
        end
    end

    for (genvar j = 0; j < WINDOW_MAX; j++)
    begin : g_cell
        logic [VAL_W-1:0] nb;
        if (j == WINDOW_MAX - 1)
        begin : g_last
            assign nb = din;
        end
        else
        begin : g_mid
            assign nb = vals[j+1];
        end
        gse_cell u_cell (
            .clk   (clk),
            .op    (ops[j]),
            .din   (din),
            .nb    (nb),
            .cand  (cand),
            .valid (CNT_W'(j) < count_reg),
            .val   (vals[j]),
            .lt    (lts[j]),
            .le    (les[j])
        );
    end

    assign lt_cnt = CNT_W'($countones(lts));
    assign le_cnt = CNT_W'($countones(les));
    assign k1     = count_m1 >> 1;
    assign k2     = count_reg >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            unique case (ctl.op)
                ROW_PUSH:  count_reg <= full ? count_reg : count_reg + 1'b1;
                ROW_TRIM,
                ROW_POP:   count_reg <= (count_reg != '0) ? count_m1 : count_reg;
                ROW_CLEAR: count_reg <= '0;
                default:   count_reg <= count_reg;
            endcase
        end
    end

    // The candidate is the k-th smallest when at most k entries lie below
    // it and more than k lie at or below it.
    always_ff @(posedge clk)
    begin
        if (ctl.med_clr)
        begin
            lo_reg <= '0;
            hi_reg <= '0;
        end
        else if (ctl.med_step && ({1'b0, ctl.sel} < count_reg))
        begin
            if (lt_cnt <= k1 && k1 < le_cnt)
                lo_reg <= cand;
            if (lt_cnt <= k2 && k2 < le_cnt)
                hi_reg <= cand;
        end
    end

    assign stat.count  = count_reg;
    assign stat.newest = vals[count_m1[IDX_W-1:0]];
    assign stat.med2   = MED_W'(lo_reg) + MED_W'(hi_reg);

endmodule

>>> sv/gse_div.sv
// Restoring divider for the stance fraction, one quotient bit per cycle.
// Depends on gse_pkg.
module gse_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [gse_pkg::VAL_W-1:0]  dividend,
    input  logic [gse_pkg::VAL_W-1:0]  divisor,
    output logic                       done,
    output logic [gse_pkg::FRAC_W-1:0] quot
);
    import gse_pkg::*;

    localparam int QB = FRAC_W - 1;

    logic [VAL_W-1:0] rem_reg;
    logic [VAL_W-1:0] dsr_reg;
    logic [QB-1:0]    q_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             sat_reg;
    logic [VAL_W:0]   rem2;
    logic [VAL_W:0]   diff;

    assign rem2 = {rem_reg, 1'b0};
    assign diff = rem2 - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= (dividend < divisor);
            done_reg <= (dividend >= divisor);
            cnt_reg  <= 5'(QB);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 5'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sat_reg <= (dividend >= divisor);
            rem_reg <= dividend;
            dsr_reg <= divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (rem2 >= {1'b0, dsr_reg})
            begin
                rem_reg <= diff[VAL_W-1:0];
                q_reg   <= {q_reg[QB-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem2[VAL_W-1:0];
                q_reg   <= {q_reg[QB-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = sat_reg ? FRAC_W'(1 << QB) : {1'b0, q_reg};

endmodule

>>> sv/gait_stance_estimator_unit.sv
// Top level of the gait stance estimator: control sequencer, registers, rows.
// Depends on gse_pkg, gse_row, gse_cell and gse_div.
//
// Use: each request on the input channel (in_valid/in_ready) carries one
// event, a heel strike (kind 0) or a toe off (kind 1) with a 48-bit time in
// nanoseconds. Every event yields exactly one request on the output channel
// (out_valid/out_ready) with a note code, the warm flag, the clean stance
// count and the predicted stance in nanoseconds.
// From acceptance to out_valid the event passes the fraction divider and the
// fraction push on an accepted cycle with a clean stance, then a trim step
// for each sample trimmed from a window that has grown past its length (up
// to 15), then the median sweep over the cell rows. One event is worked on
// at a time: a new request is accepted only once the sequencer is idle again.
// The result sits in an output register; a new request is accepted while it
// waits, and when the receiver stalls the next result waits in its last step
// until the register is free.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// belong in idle periods. Reset restores the default registers and empties
// all windows; no clearing pass is needed.
module gait_stance_estimator_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [gse_pkg::MS_W-1:0]    cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        kind,
    input  logic [gse_pkg::TIME_W-1:0]  event_time,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  note_code,
    output logic                        is_warm,
    output logic [gse_pkg::CNT_W-1:0]   clean_count,
    output logic [gse_pkg::VAL_W-1:0]   predicted_stance
);
    import gse_pkg::*;

    localparam int MF_W   = FRAC_W + 1;
    localparam int PROD_W = VAL_W + MF_W;
    localparam int HALF   = VAL_W / 2;
    localparam int CAD_W  = VAL_W + 7;

    // Configuration registers.
    logic [4:0]      win_len_reg;
    logic [4:0]      warmup_reg;
    logic [MS_W-1:0] gap_reg;
    logic [MS_W-1:0] cmin_reg;
    logic [MS_W-1:0] cmax_reg;
    logic [MS_W-1:0] smin_reg;
    logic [MS_W-1:0] smax_reg;
    logic [6:0]      pct_reg;

    // Tracker state.
    state_t            state_reg;
    state_t            state_next;
    logic [TIME_W-1:0] prev_reg;
    logic              have_prev_reg;
    logic              open_reg;
    logic [VAL_W-1:0]  cstance_reg;
    logic [VAL_W-1:0]  last_reg;

    // Per-event working registers.
    logic              kind_reg;
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] diff_reg;
    logic              le_reg;
    logic              ltp_reg;
    logic [VAL_W-1:0]  gap_ns_reg;
    logic [VAL_W-1:0]  lo_ns_reg;
    logic [VAL_W-1:0]  hi_ns_reg;
    logic [1:0]        note_reg;
    logic [2:0]        pushf_reg;
    logic [IDX_W-1:0]  sel_reg;
    logic [VAL_W-1:0]  medp_reg;
    logic [CAD_W-1:0]  dev100_reg;
    logic [CAD_W-1:0]  pctmed_reg;
    logic [VAL_W-1:0]  cycle_reg;
    logic [VAL_W-1:0]  plo_reg;
    logic [PROD_W-1:0] prod_reg;

    // Output register.
    logic              out_valid_reg;
    logic [1:0]        note_out_reg;
    logic              warm_out_reg;
    logic [CNT_W-1:0]  count_out_reg;
    logic [VAL_W-1:0]  pred_out_reg;

    row_ctl_t          ctl_p;
    row_ctl_t          ctl_s;
    row_ctl_t          ctl_f;
    row_stat_t         st_p;
    row_stat_t         st_s;
    row_stat_t         st_f;
    logic              div_start;
    logic              div_done;
    logic [FRAC_W-1:0] quot;

    logic [CNT_W-1:0]  eff_win;
    logic [CNT_W-1:0]  eff_warm;
    logic              warm;
    logic              gap_hit;
    logic              out_bounds;
    logic              drop_newest;
    logic              trim_p;
    logic              trim_s;
    logic              trim_f;
    logic              out_load;
    logic [VAL_W-1:0]  med_p;
    logic [VAL_W-1:0]  dev;
    logic [MF_W-1:0]   mf;
    logic [VAL_W-1:0]  pred;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        if (win_len_reg == '0)
            eff_win = CNT_W'(1);
        else if (win_len_reg > CNT_W'(WINDOW_MAX))
            eff_win = CNT_W'(WINDOW_MAX);
        else
            eff_win = win_len_reg;
    end

    assign eff_warm = (warmup_reg == '0) ? CNT_W'(1) : warmup_reg;
    assign warm     = (st_s.count >= eff_warm);

    // A strike no later than the previous one counts as a gap.
    assign gap_hit     = le_reg || (diff_reg > TIME_W'(gap_ns_reg));
    assign out_bounds  = (diff_reg < TIME_W'(lo_ns_reg)) || (diff_reg > TIME_W'(hi_ns_reg));
    assign drop_newest = (cstance_reg != '0) && (st_s.count != '0)
                         && (st_s.newest == cstance_reg);
    assign trim_p      = pushf_reg[0] && (st_p.count > eff_win);
    assign trim_s      = pushf_reg[1] && (st_s.count > eff_win);
    assign trim_f      = pushf_reg[2] && (st_f.count > eff_win);
    assign out_load    = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    assign med_p = st_p.med2[MED_W-1:1];
    assign dev   = (last_reg > medp_reg) ? last_reg - medp_reg : medp_reg - last_reg;
    assign mf    = st_f.med2[MF_W-1:0];

    always_comb
    begin
        if (!warm)
            pred = '0;
        else if (st_f.count != '0 && cycle_reg != '0)
            pred = prod_reg[VAL_W+FRAC_W-1:FRAC_W];
        else
            pred = st_s.med2[MED_W-1:1];
    end

    // Sequencer: next state and the commands to the rows and the divider.
    always_comb
    begin
        state_next = state_reg;
        ctl_p      = '{op: ROW_IDLE, med_clr: 1'b0, med_step: 1'b0, sel: sel_reg};
        ctl_s      = ctl_p;
        ctl_f      = ctl_p;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_THR;
            end
            ST_THR:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = ST_TRIM;
                if (!kind_reg)
                begin
                    if (have_prev_reg)
                    begin
                        if (gap_hit)
                        begin
                            ctl_p.op = ROW_CLEAR;
                            ctl_s.op = ROW_CLEAR;
                            ctl_f.op = ROW_CLEAR;
                        end
                        else if (out_bounds)
                        begin
                            if (drop_newest)
                                ctl_s.op = ROW_POP;
                        end
                        else
                        begin
                            ctl_p.op = ROW_PUSH;
                            if (cstance_reg != '0)
                            begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                    end
                end
                else if (open_reg && !ltp_reg && !out_bounds)
                begin
                    ctl_s.op = ROW_PUSH;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_FPUSH;
            end
            ST_FPUSH:
            begin
                ctl_f.op   = ROW_PUSH;
                state_next = ST_TRIM;
            end
            ST_TRIM:
            begin
                // Windows longer than their length lose one sample a cycle.
                if (trim_p)
                    ctl_p.op = ROW_TRIM;
                if (trim_s)
                    ctl_s.op = ROW_TRIM;
                if (trim_f)
                    ctl_f.op = ROW_TRIM;
                if (!trim_p && !trim_s && !trim_f)
                begin
                    ctl_p.med_clr = 1'b1;
                    ctl_s.med_clr = 1'b1;
                    ctl_f.med_clr = 1'b1;
                    state_next    = ST_MED;
                end
            end
            ST_MED:
            begin
                ctl_p.med_step = 1'b1;
                ctl_s.med_step = 1'b1;
                ctl_f.med_step = 1'b1;
                if (sel_reg == IDX_W'(WINDOW_MAX - 1))
                    state_next = ST_CAD;
            end
            ST_CAD:    state_next = ST_CHOOSE;
            ST_CHOOSE: state_next = ST_MUL0;
            ST_MUL0:   state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg <= 5'd8;
            warmup_reg  <= 5'd3;
            gap_reg     <= 16'd3000;
            cmin_reg    <= 16'd600;
            cmax_reg    <= 16'd2000;
            smin_reg    <= 16'd200;
            smax_reg    <= 16'd1500;
            pct_reg     <= 7'd15;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LEN: win_len_reg <= cfg_data[4:0];
                CFG_WARMUP:     warmup_reg  <= cfg_data[4:0];
                CFG_GAP:        gap_reg     <= cfg_data;
                CFG_CYCLE_MIN:  cmin_reg    <= cfg_data;
                CFG_CYCLE_MAX:  cmax_reg    <= cfg_data;
                CFG_STANCE_MIN: smin_reg    <= cfg_data;
                CFG_STANCE_MAX: smax_reg    <= cfg_data;
                CFG_CADENCE:    pct_reg     <= cfg_data[6:0];
                default:        pct_reg     <= pct_reg;
            endcase
        end
    end

    // Tracker state: previous strike, open stance, last good cycle, note, push flags and sweep index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            open_reg      <= 1'b0;
            cstance_reg   <= '0;
            last_reg      <= '0;
            pushf_reg     <= '0;
            note_reg      <= NOTE_NONE;
            sel_reg       <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                pushf_reg <= '0;
                note_reg  <= NOTE_NONE;
            end
            if (state_reg == ST_EVAL)
            begin
                if (!kind_reg)
                begin
                    if (have_prev_reg)
                    begin
                        if (gap_hit)
                        begin
                            note_reg <= NOTE_GAP;
                            last_reg <= '0;
                        end
                        else if (out_bounds)
                        begin
                            note_reg <= NOTE_CYCLE;
                        end
                        else
                        begin
                            last_reg     <= diff_reg[VAL_W-1:0];
                            pushf_reg[0] <= 1'b1;
                        end
                    end
                    have_prev_reg <= 1'b1;
                    prev_reg      <= time_reg;
                    open_reg      <= 1'b1;
                    cstance_reg   <= '0;
                end
                else if (open_reg)
                begin
                    open_reg <= 1'b0;
                    if (ltp_reg || out_bounds)
                    begin
                        cstance_reg <= '0;
                        note_reg    <= NOTE_STANCE;
                    end
                    else
                    begin
                        cstance_reg  <= diff_reg[VAL_W-1:0];
                        pushf_reg[1] <= 1'b1;
                    end
                end
            end
            if (state_reg == ST_FPUSH)
                pushf_reg[2] <= 1'b1;
            if (state_reg == ST_MED)
                sel_reg <= sel_reg + 1'b1;
            else
                sel_reg <= '0;
        end
    end

    // Datapath registers of one event.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg <= kind;
            time_reg <= event_time;
        end
        if (state_reg == ST_THR)
        begin
            diff_reg   <= time_reg - prev_reg;
            le_reg     <= (time_reg <= prev_reg);
            ltp_reg    <= (time_reg < prev_reg);
            gap_ns_reg <= VAL_W'(gap_reg) * VAL_W'(NS_PER_MS);
            lo_ns_reg  <= VAL_W'(kind_reg ? smin_reg : cmin_reg) * VAL_W'(NS_PER_MS);
            hi_ns_reg  <= VAL_W'(kind_reg ? smax_reg : cmax_reg) * VAL_W'(NS_PER_MS);
        end
        if (state_reg == ST_CAD)
        begin
            medp_reg <= med_p;
        end
        if (state_reg == ST_CHOOSE)
        begin
            dev100_reg <= CAD_W'(dev) * CAD_W'(100);
            pctmed_reg <= CAD_W'(pct_reg) * CAD_W'(medp_reg);
        end
        if (state_reg == ST_MUL0)
        begin
            // The cycle is the last one when it strays too far from the median.
            if (st_p.count == '0 || last_reg == '0 || medp_reg == '0)
                cycle_reg <= last_reg;
            else if (dev100_reg > pctmed_reg)
                cycle_reg <= last_reg;
            else
                cycle_reg <= medp_reg;
        end
        if (state_reg == ST_MUL1)
        begin
            plo_reg <= VAL_W'(mf) * VAL_W'(cycle_reg[HALF-1:0]);
        end
        // The full product is ready before the result may leave.
        if (state_reg == ST_MUL2)
        begin
            prod_reg <= PROD_W'(plo_reg)
                        + ((PROD_W'(mf) * PROD_W'(cycle_reg[VAL_W-1:HALF])) << HALF);
        end
    end

    // Output register, freed by the receiver.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            note_out_reg  <= note_reg;
            warm_out_reg  <= warm;
            count_out_reg <= st_s.count;
            pred_out_reg  <= pred;
        end
    end

    gse_row u_row_period (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl_p),
        .din   (diff_reg[VAL_W-1:0]),
        .stat  (st_p)
    );

    gse_row u_row_stance (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl_s),
        .din   (diff_reg[VAL_W-1:0]),
        .stat  (st_s)
    );

    gse_row u_row_frac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl_f),
        .din   (VAL_W'(quot)),
        .stat  (st_f)
    );

    gse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cstance_reg),
        .divisor  (diff_reg[VAL_W-1:0]),
        .done     (div_done),
        .quot     (quot)
    );

    assign out_valid        = out_valid_reg;
    assign note_code        = note_out_reg;
    assign is_warm          = warm_out_reg;
    assign clean_count      = count_out_reg;
    assign predicted_stance = pred_out_reg;

    // A delivered prediction is zero unless the block was warm.
    a_pred_needs_warm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (warm_out_reg || pred_out_reg == '0))
        else $error("prediction given while not warm");

    // Windows never hold more samples than a row has cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_s.count <= CNT_W'(WINDOW_MAX) && st_p.count <= CNT_W'(WINDOW_MAX)
        && st_f.count <= CNT_W'(WINDOW_MAX))
        else $error("window count beyond row length");

    // An accepted request starts the threshold step in the next cycle.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_THR))
        else $error("accepted request did not start");

    // The divider only finishes while the sequencer waits for it.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait state");

endmodule
